### design/binary_semaphore_wait_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary semaphore wait queue unit
// Shared concurrent assertion forms used by bswq_back.
// ----------------------------------------------------------------------------
`ifndef BINARY_SEMAPHORE_WAIT_QUEUE_UNIT_DEFINES_SVH
`define BINARY_SEMAPHORE_WAIT_QUEUE_UNIT_DEFINES_SVH

// Property that must hold on every clock edge outside reset
`define BSWQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Implication: antecedent on one edge, consequent on the same edge
`define BSWQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/bswq_pkg.sv
// ----------------------------------------------------------------------------
// bswq_pkg
// Sizes, codes and item types shared by the semaphore wait queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bswq_pkg;

	// table sizes
	localparam int NUM_SEMAPHORES = 32;
	localparam int NUM_TASKS      = 64;

	// port field widths
	localparam int SEM_W    = 6;
	localparam int TASK_W   = 6;
	localparam int STATUS_W = 3;

	// internal index widths
	localparam int SEM_IDX_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int TASK_IDX_W = $clog2(NUM_TASKS);

	// front-to-back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// lock states
	localparam logic OPEN   = 1'b0;
	localparam logic CLOSED = 1'b1;

	typedef logic [SEM_W:0]  sem_ext_t;
	typedef logic [TASK_W:0] task_ext_t;

	typedef enum logic {
		CMD_WAIT = 1'b0,
		CMD_POST = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_GRANTED      = 3'd0,
		STAT_BLOCKED      = 3'd1,
		STAT_ALREADY_OPEN = 3'd2,
		STAT_OPENED       = 3'd3,
		STAT_WOKE         = 3'd4,
		STAT_BAD_INDEX    = 3'd5
	} status_t;

	// classified item as passed from front to back
	typedef struct packed {
		cmd_t                  cmd;
		logic [SEM_IDX_W-1:0]  sem;
		logic [TASK_IDX_W-1:0] tid;
		logic                  bad;
	} item_t;

	// one entry of the shared next-link table
	typedef struct packed {
		logic                  has_next;
		logic [TASK_IDX_W-1:0] next;
	} link_t;

endpackage

### design/bswq_front.sv
// ----------------------------------------------------------------------------
// bswq_front
// Accepts items, checks the semaphore and task numbers, and queues the
// classified items for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bswq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        command,
	input  logic [bswq_pkg::SEM_W-1:0]  sem_index,
	input  logic [bswq_pkg::TASK_W-1:0] task_id,
	output logic                        item_valid,
	output bswq_pkg::item_t             item,
	input  logic                        item_take
);
	import bswq_pkg::*;

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	item_t              classified;
	logic               accept;
	logic               sem_ok;
	logic               task_ok;

	// range checks; the task number only matters for a wait
	always_comb begin
		sem_ok  = {1'b0, sem_index} < sem_ext_t'(NUM_SEMAPHORES);
		task_ok = {1'b0, task_id} < task_ext_t'(NUM_TASKS);
		classified.cmd = cmd_t'(command);
		classified.sem = sem_index[SEM_IDX_W-1:0];
		classified.tid = task_id[TASK_IDX_W-1:0];
		classified.bad = !sem_ok || ((cmd_t'(command) == CMD_WAIT) && !task_ok);
	end

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign accept     = push && !full;
	assign item_valid = (count_q != '0);
	assign item       = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (item_take) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (accept && !item_take) begin
				count_q <= count_q + 1'b1;
			end else if (!accept && item_take) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/bswq_back.sv
// ----------------------------------------------------------------------------
// bswq_back
// Carries out classified items against the lock table, the per-semaphore
// head and tail memories and the shared link memory; holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "binary_semaphore_wait_queue_unit_defines.svh"

module bswq_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  bswq_pkg::item_t             item,
	output logic                        item_take,
	output logic                        out_valid,
	input  logic                        pop,
	output bswq_pkg::status_t           out_status,
	output logic [bswq_pkg::TASK_W-1:0] out_woken_task,
	output logic                        out_woken_valid
);
	import bswq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LINK,
		ST_NEXT
	} state_t;

	state_t                    state_q;
	item_t                     cur_q;
	logic [NUM_SEMAPHORES-1:0] lock_closed_q;
	logic [NUM_SEMAPHORES-1:0] nonempty_q;
	logic                      out_valid_q;
	status_t                   out_status_q;
	logic [TASK_W-1:0]         out_woken_task_q;
	logic                      out_woken_valid_q;

	logic [TASK_IDX_W-1:0] head_mem [NUM_SEMAPHORES];
	logic [TASK_IDX_W-1:0] tail_mem [NUM_SEMAPHORES];
	link_t                 link_mem [NUM_TASKS];
	logic [TASK_IDX_W-1:0] head_rd_q;
	logic [TASK_IDX_W-1:0] tail_rd_q;
	link_t                 link_rd_q;

	logic                  take;
	logic                  cur_lock;
	logic                  cur_ne;
	logic                  head_we;
	logic [TASK_IDX_W-1:0] head_wd;
	logic                  tail_we;
	logic                  link_we;
	logic [TASK_IDX_W-1:0] link_wa;
	link_t                 link_wd;
	logic                  link_re;

	assign take      = (state_q == ST_IDLE) && item_valid && !out_valid_q;
	assign item_take = take;
	assign cur_lock  = lock_closed_q[cur_q.sem];
	assign cur_ne    = nonempty_q[cur_q.sem];

	// memory write and read strobes per state
	always_comb begin
		head_we = 1'b0;
		head_wd = cur_q.tid;
		tail_we = 1'b0;
		link_we = 1'b0;
		link_wa = cur_q.tid;
		link_wd = '0;
		link_re = 1'b0;
		case (state_q)
			ST_EXEC: begin
				if (cur_q.cmd == CMD_WAIT) begin
					if (cur_lock == CLOSED) begin
						// caller goes to the tail with no successor
						link_we = 1'b1;
						tail_we = 1'b1;
						head_we = !cur_ne;
					end
				end else if ((cur_lock == CLOSED) && cur_ne) begin
					link_re = 1'b1;
				end
			end
			ST_LINK: begin
				// chain the old tail to the caller
				link_we          = 1'b1;
				link_wa          = tail_rd_q;
				link_wd.has_next = 1'b1;
				link_wd.next     = cur_q.tid;
			end
			ST_NEXT: begin
				head_we = link_rd_q.has_next;
				head_wd = link_rd_q.next;
			end
			default: begin
			end
		endcase
	end

	// head and tail memories, read when an item is taken
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[cur_q.sem] <= head_wd;
		end
		if (tail_we) begin
			tail_mem[cur_q.sem] <= cur_q.tid;
		end
		if (take) begin
			head_rd_q <= head_mem[item.sem];
			tail_rd_q <= tail_mem[item.sem];
		end
	end

	// shared link memory, read at the current head on a wake
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd_q <= link_mem[head_rd_q];
		end
	end

	// sequencer, lock flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			cur_q             <= '0;
			lock_closed_q     <= '0;
			nonempty_q        <= '0;
			out_valid_q       <= 1'b0;
			out_status_q      <= STAT_GRANTED;
			out_woken_task_q  <= '0;
			out_woken_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						cur_q <= item;
						if (item.bad) begin
							out_valid_q       <= 1'b1;
							out_status_q      <= STAT_BAD_INDEX;
							out_woken_task_q  <= '0;
							out_woken_valid_q <= 1'b0;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					out_woken_task_q  <= '0;
					out_woken_valid_q <= 1'b0;
					if (cur_q.cmd == CMD_WAIT) begin
						if (cur_lock == OPEN) begin
							lock_closed_q[cur_q.sem] <= CLOSED;
							out_valid_q              <= 1'b1;
							out_status_q             <= STAT_GRANTED;
							state_q                  <= ST_IDLE;
						end else begin
							nonempty_q[cur_q.sem] <= 1'b1;
							if (cur_ne) begin
								state_q <= ST_LINK;
							end else begin
								out_valid_q  <= 1'b1;
								out_status_q <= STAT_BLOCKED;
								state_q      <= ST_IDLE;
							end
						end
					end else begin
						if (cur_lock == OPEN) begin
							out_valid_q  <= 1'b1;
							out_status_q <= STAT_ALREADY_OPEN;
							state_q      <= ST_IDLE;
						end else if (!cur_ne) begin
							lock_closed_q[cur_q.sem] <= OPEN;
							out_valid_q              <= 1'b1;
							out_status_q             <= STAT_OPENED;
							state_q                  <= ST_IDLE;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_LINK: begin
					out_valid_q  <= 1'b1;
					out_status_q <= STAT_BLOCKED;
					state_q      <= ST_IDLE;
				end
				ST_NEXT: begin
					// last waiter leaves: the queue empties, lock stays closed
					if (!link_rd_q.has_next) begin
						nonempty_q[cur_q.sem] <= 1'b0;
					end
					out_valid_q       <= 1'b1;
					out_status_q      <= STAT_WOKE;
					out_woken_task_q  <= TASK_W'(head_rd_q);
					out_woken_valid_q <= 1'b1;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_woken_task  = out_woken_task_q;
	assign out_woken_valid = out_woken_valid_q;

	// a result only waits while the sequencer is idle
	`BSWQ_ASSERT_IMP(a_busy_no_result, clk, arst_n, state_q != ST_IDLE,
		!out_valid_q, "result held while busy")
	// a wake is reached only from execute, on a closed semaphore with waiters
	`BSWQ_ASSERT_IMP(a_wake_closed, clk, arst_n, state_q == ST_NEXT,
		(cur_lock == CLOSED) && cur_ne, "wake on open or empty semaphore")
	// link step only follows the execute step
	`BSWQ_ASSERT_IMP(a_link_order, clk, arst_n, state_q == ST_LINK,
		$past(state_q) == ST_EXEC, "link step out of order")
	// the woken flag matches the status code
	`BSWQ_ASSERT_IMP(a_woken_flag, clk, arst_n, out_valid_q,
		out_woken_valid_q == (out_status_q == STAT_WOKE), "woken flag disagrees with status")

endmodule

### design/binary_semaphore_wait_queue_unit.sv
// Steps: a result for a bad index is registered as the back end takes the item; grant, open
// and already open come from the execute step, a block from execute or link, a wake from next.
// The back end takes an item only while idle and while no result waits; linking a blocked
// caller or a wake adds one step.
// Reset: asynchronous, clears all locks to open and all wait queues to empty at once;
// pointer and link memories need no clearing pass.
// ----------------------------------------------------------------------------
// binary_semaphore_wait_queue_unit
// Binary semaphore table with a FIFO wait queue of task numbers per semaphore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_semaphore_wait_queue_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          command,
	input  logic [bswq_pkg::SEM_W-1:0]    sem_index,
	input  logic [bswq_pkg::TASK_W-1:0]   task_id,
	output logic                          empty,
	input  logic                          pop,
	output logic [bswq_pkg::STATUS_W-1:0] status,
	output logic [bswq_pkg::TASK_W-1:0]   woken_task,
	output logic                          woken_valid
);
	import bswq_pkg::*;

	logic    item_valid;
	item_t   item;
	logic    item_take;
	logic    res_valid;
	status_t res_status;

	// accept and classify
	bswq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.sem_index  (sem_index),
		.task_id    (task_id),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	// execute against the semaphore tables
	bswq_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item            (item),
		.item_take       (item_take),
		.out_valid       (res_valid),
		.pop             (pop),
		.out_status      (res_status),
		.out_woken_task  (woken_task),
		.out_woken_valid (woken_valid)
	);

	assign empty  = !res_valid;
	assign status = res_status;

endmodule
